// ===== rtl/maf_pkg.sv =====
// Shared constants, types and a helper function of the moving average filter.
package maf_pkg;

    // Sizing
    localparam int MAX_WINDOW      = 64;
    localparam int SAMPLE_WIDTH    = 16;
    localparam int CFG_W           = 7;
    localparam int WINDOW_AT_RESET = 8;
    localparam int PTR_W           = $clog2(MAX_WINDOW);
    localparam int WIN_W           = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W           = SAMPLE_WIDTH + PTR_W;
    localparam int CNT_W           = $clog2(SUM_W + 1);

    // Command from the control path to the serial divider
    typedef struct packed {
        logic start;
        logic negate;
    } div_cmd_t;

    // Window register write: zero becomes one, large values saturate
    function automatic logic [WIN_W-1:0] clamp_window(input logic [CFG_W-1:0] v);
        logic [WIN_W-1:0] r;
        if (v == '0)
            r = WIN_W'(1);
        else if (32'(v) > MAX_WINDOW)
            r = WIN_W'(MAX_WINDOW);
        else
            r = WIN_W'(v);
        return r;
    endfunction

endpackage

// ===== rtl/moving_average_filter.sv =====
// One sample at a time: a new sample request is taken only in the idle state, after the
//   previous average has gone to the output register (which waits while the receiver stalls);
//   the bit-serial divider works one quotient bit per cycle over the 22-bit running sum.
// Reset (rst_n, asynchronous, active low): window 8, ring, sum, pointer and fill
//   count cleared; ring entries read as zero through per-entry valid bits.
// A window write clears the filter state the same way.
module moving_average_filter (
    input  logic                              clk,
    input  logic                              rst_n,
    // Sample stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [maf_pkg::SAMPLE_WIDTH-1:0]  s_axis_tdata,   // [15:0] sample
    // Average stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [maf_pkg::SAMPLE_WIDTH-1:0]  m_axis_tdata,   // [15:0] average
    // Window size register write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [maf_pkg::CFG_W-1:0]         cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV
    } state_t;

    state_t                                   state_reg;
    logic signed [maf_pkg::SAMPLE_WIDTH-1:0]  sample_reg;
    logic [maf_pkg::PTR_W-1:0]                ptr_reg;
    logic [maf_pkg::PTR_W-1:0]                addr_reg;
    logic [maf_pkg::WIN_W-1:0]                fill_reg;
    logic [maf_pkg::WIN_W-1:0]                win_reg;
    logic signed [maf_pkg::SUM_W-1:0]         sum_reg;
    logic [maf_pkg::MAX_WINDOW-1:0]           valid_reg;
    logic                                     hit_reg;
    logic                                     out_valid_reg;
    logic [maf_pkg::SAMPLE_WIDTH-1:0]         out_data_reg;

    logic                                     in_req;
    logic                                     cfg_req;
    logic                                     out_free;
    logic [maf_pkg::PTR_W-1:0]                addr_sel;
    logic [maf_pkg::WIN_W-1:0]                addr_inc;
    logic [maf_pkg::PTR_W-1:0]                ptr_next;
    logic [maf_pkg::WIN_W-1:0]                fill_next;
    logic [maf_pkg::SAMPLE_WIDTH-1:0]         ram_rdata;
    logic signed [maf_pkg::SAMPLE_WIDTH-1:0]  old_smp;
    logic signed [maf_pkg::SUM_W-1:0]         sum_next;
    logic [maf_pkg::SUM_W-1:0]                sum_mag;
    logic                                     ram_we;
    maf_pkg::div_cmd_t                        div_cmd;
    logic                                     div_done;
    logic [maf_pkg::SAMPLE_WIDTH-1:0]         div_quot;

    // Handshakes
    assign cfg_ready     = (state_reg == ST_IDLE);
    assign s_axis_tready = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_req       = cfg_valid && cfg_ready;
    assign in_req        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Ring slot for the incoming sample, wrapping at the window
    assign addr_sel = ({1'b0, ptr_reg} >= win_reg) ? '0 : ptr_reg;

    // Running sum update with the overwritten entry
    always_comb
    begin
        addr_inc  = {1'b0, addr_reg} + 1'b1;
        ptr_next  = (addr_inc < win_reg) ? addr_inc[maf_pkg::PTR_W-1:0] : '0;
        fill_next = (fill_reg < win_reg) ? fill_reg + 1'b1 : win_reg;
        old_smp   = hit_reg ? ram_rdata : '0;
        sum_next  = sum_reg + maf_pkg::SUM_W'(sample_reg) - maf_pkg::SUM_W'(old_smp);
        sum_mag   = sum_next[maf_pkg::SUM_W-1] ? maf_pkg::SUM_W'(-sum_next)
                                               : maf_pkg::SUM_W'(sum_next);
        ram_we         = (state_reg == ST_READ);
        div_cmd.start  = (state_reg == ST_READ);
        div_cmd.negate = sum_next[maf_pkg::SUM_W-1];
    end

    maf_ram #(
        .WIDTH(maf_pkg::SAMPLE_WIDTH),
        .DEPTH(maf_pkg::MAX_WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (sample_reg),
        .raddr (addr_sel),
        .rdata (ram_rdata)
    );

    maf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (div_cmd),
        .dividend (sum_mag),
        .divisor  (fill_next),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Control state machine and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sample_reg    <= '0;
            ptr_reg       <= '0;
            addr_reg      <= '0;
            fill_reg      <= '0;
            win_reg       <= maf_pkg::WIN_W'(maf_pkg::WINDOW_AT_RESET);
            sum_reg       <= '0;
            valid_reg     <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            // Result taken by the receiver, unless a new one replaces it
            if (out_valid_reg && m_axis_tready && !((state_reg == ST_DIV) && div_done))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cfg_req)
                    begin
                        win_reg   <= maf_pkg::clamp_window(cfg_data);
                        ptr_reg   <= '0;
                        fill_reg  <= '0;
                        sum_reg   <= '0;
                        valid_reg <= '0;
                    end
                    else if (in_req)
                    begin
                        sample_reg <= s_axis_tdata;
                        addr_reg   <= addr_sel;
                        hit_reg    <= valid_reg[addr_sel];
                        state_reg  <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    sum_reg             <= sum_next;
                    valid_reg[addr_reg] <= 1'b1;
                    ptr_reg             <= ptr_next;
                    fill_reg            <= fill_next;
                    state_reg           <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_done && out_free)
                    begin
                        out_data_reg  <= div_quot;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/maf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module maf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/maf_div.sv =====
// Bit-serial restoring divider: magnitude of the running sum by the sample count.
module maf_div (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  maf_pkg::div_cmd_t                     cmd,
    input  logic [maf_pkg::SUM_W-1:0]             dividend,
    input  logic [maf_pkg::WIN_W-1:0]             divisor,
    output logic                                  done,
    output logic [maf_pkg::SAMPLE_WIDTH-1:0]      quotient
);

    logic [maf_pkg::SUM_W-1:0]   quo_reg, quo_next;
    logic [maf_pkg::WIN_W-1:0]   rem_reg, rem_next;
    logic [maf_pkg::WIN_W-1:0]   div_reg;
    logic [maf_pkg::CNT_W-1:0]   cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic                        neg_reg;
    logic [maf_pkg::WIN_W:0]     trial;
    logic [maf_pkg::WIN_W:0]     diff;
    logic                        fits;
    logic [maf_pkg::SAMPLE_WIDTH-1:0] q_low;

    // One quotient bit per cycle: shift the next dividend bit into the remainder
    always_comb
    begin
        trial    = {rem_reg, quo_reg[maf_pkg::SUM_W-1]};
        diff     = trial - {1'b0, div_reg};
        fits     = (trial >= {1'b0, div_reg});
        rem_next = fits ? diff[maf_pkg::WIN_W-1:0] : trial[maf_pkg::WIN_W-1:0];
        quo_next = {quo_reg[maf_pkg::SUM_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            div_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            neg_reg  <= 1'b0;
        end
        else if (cmd.start)
        begin
            quo_reg  <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
            cnt_reg  <= maf_pkg::CNT_W'(maf_pkg::SUM_W);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            neg_reg  <= cmd.negate;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == maf_pkg::CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Result lies in the sample range; restore the sign (truncation toward zero)
    assign q_low    = quo_reg[maf_pkg::SAMPLE_WIDTH-1:0];
    assign quotient = neg_reg ? (~q_low + 1'b1) : q_low;
    assign done     = done_reg;

endmodule

// ===== rtl/maf_checker.sv =====
// Port-level checks of the moving average filter, bound to the top level.
module maf_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [maf_pkg::SAMPLE_WIDTH-1:0]  s_axis_tdata,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [maf_pkg::SAMPLE_WIDTH-1:0]  m_axis_tdata,
    input logic                              cfg_valid,
    input logic                              cfg_ready,
    input logic [maf_pkg::CFG_W-1:0]         cfg_data
);

    logic in_req;
    logic cfg_req;

    assign in_req  = s_axis_tvalid && s_axis_tready;
    assign cfg_req = cfg_valid && cfg_ready;

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("average changed while stalled");

    // One sample at a time: busy right after a request
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_req |=> !s_axis_tready && !cfg_ready)
        else $error("request taken while a sample is in work");

    // A window write and a sample never land on the same edge
    a_cfg_excl: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_req |-> !in_req)
        else $error("window write and sample request together");

    // No result shows up in the cycle right after a sample request
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        in_req |=> !$rose(m_axis_tvalid))
        else $error("result appeared too early");

    // Request payloads carry known values
    a_req_known: assert property (@(posedge clk) disable iff (!rst_n)
        (in_req |-> !$isunknown(s_axis_tdata)) and (cfg_req |-> !$isunknown(cfg_data)))
        else $error("unknown data on a request");

endmodule

bind moving_average_filter maf_checker u_maf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
);
